// ===== rtl/mbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbsp_pkg
// Types and constants shared by the MIDI byte stream parser modules.
// ----------------------------------------------------------------------------
package mbsp_pkg;

	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_END   = 8'hF7;
	localparam logic [3:0] SYS_NIBBLE  = 4'hF;
	localparam logic [3:0] PROG_NIBBLE = 4'hC;
	localparam logic [6:0] SYSEX_DATA_TAG = 7'd1;
	localparam logic [6:0] SYSEX_END_TAG  = 7'd2;
	localparam int unsigned OUT_BITS = 24;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_FIRST  = 3'd1,
		MODE_SECOND = 3'd2,
		MODE_SYSEX  = 3'd3,
		MODE_SINGLE = 3'd4
	} parse_mode_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] command;
		logic [6:0] first_field;
		logic [6:0] second_field;
	} mbsp_result_t;

endpackage

// ===== rtl/mbsp_decode.sv =====
// ----------------------------------------------------------------------------
// mbsp_decode
// Parse state and per-byte decode; produces at most one message per step.
// ----------------------------------------------------------------------------
module mbsp_decode
	import mbsp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   midi_byte,
	output mbsp_result_t result
);

	parse_mode_t mode_q, mode_d;
	logic [7:0]  status_q, status_d;
	logic [6:0]  held_q, held_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			status_q <= '0;
			held_q   <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			status_q <= status_d;
			held_q   <= held_d;
		end
	end

	always_comb begin
		mode_d       = mode_q;
		status_d     = status_q;
		held_d       = held_q;
		result       = '0;
		if (midi_byte[7:4] == SYS_NIBBLE) begin
			result.valid   = 1'b1;
			result.command = midi_byte;
			if (midi_byte == SYSEX_START) begin
				mode_d = MODE_SYSEX;
			end else if (midi_byte == SYSEX_END) begin
				mode_d = MODE_IDLE;
				result.first_field = SYSEX_END_TAG;
			end
		end else if (midi_byte[7]) begin
			status_d = midi_byte;
			mode_d   = (midi_byte[7:4] == PROG_NIBBLE) ? MODE_SINGLE : MODE_FIRST;
		end else begin
			case (mode_q)
				MODE_SYSEX: begin
					result.valid        = 1'b1;
					result.command      = SYSEX_START;
					result.first_field  = SYSEX_DATA_TAG;
					result.second_field = midi_byte[6:0];
				end
				MODE_FIRST: begin
					held_d = midi_byte[6:0];
					mode_d = MODE_SECOND;
				end
				MODE_SECOND: begin
					mode_d              = MODE_FIRST;
					result.valid        = 1'b1;
					result.command      = status_q;
					result.first_field  = held_q;
					result.second_field = midi_byte[6:0];
				end
				MODE_SINGLE: begin
					result.valid       = 1'b1;
					result.command     = status_q;
					result.first_field = midi_byte[6:0];
				end
				default: begin
					mode_d = MODE_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step && midi_byte == SYSEX_END |=> mode_q == MODE_IDLE)
		else $error("sysex end did not return to idle");
	a_status_silent: assert property (@(posedge clk) disable iff (!arst_n)
		midi_byte[7] && midi_byte[7:4] != SYS_NIBBLE |-> !result.valid)
		else $error("channel status produced a message");
	a_sysex_data: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_SYSEX && !midi_byte[7] |->
		result.valid && result.command == SYSEX_START)
		else $error("sysex data byte not reported");
`endif

endmodule

// ===== rtl/mbsp_out_reg.sv =====
// ----------------------------------------------------------------------------
// mbsp_out_reg
// Result register holding one decoded message until its transfer completes.
// ----------------------------------------------------------------------------
module mbsp_out_reg
	import mbsp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  mbsp_result_t        result,
	output logic                can_load,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_BITS-1:0] m_tdata
);

	logic       valid_q;
	logic [7:0] command_q;
	logic [6:0] first_q, second_q;

	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load && result.valid) begin
			command_q <= result.command;
			first_q   <= result.first_field;
			second_q  <= result.second_field;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, second_q, first_q, command_q};

endmodule

// ===== rtl/midi_byte_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_unit
// MIDI byte parser with running status: one byte in, at most one message out.
//
//   channel   dir  tdata (low bit up)                        notes
//   s_axis    in   midi_byte[7:0]                            one byte per transfer
//   m_axis    out  command[7:0] first_field[14:8]            bits 23:22 zero
//                  second_field[21:15]
//
// One byte per cycle sustained while m_axis is not stalled; a message passes the
// input register, then the result register, after its last byte is taken.
// Reset clears the parse mode, running status and held data byte.
// A stalled result register holds the input register, which then stalls s_axis.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_unit
	import mbsp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // midi_byte[7:0]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_BITS-1:0] m_axis_tdata    // command, first_field, second_field, pad
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         can_load;
	logic         step;
	mbsp_result_t result;

	assign step          = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	mbsp_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.midi_byte (byte_s1),
		.result    (result)
	);

	mbsp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.result   (result),
		.can_load (can_load),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipeline stalled");
	a_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && byte_s1 == $past(byte_s1))
		else $error("stalled input byte lost");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.valid |=> m_axis_tvalid)
		else $error("decoded message not presented");
`endif

endmodule

// ===== sim/midi_parse_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_parse_checker
// Watches both stream channels of the MIDI byte parser, tracks parse mode,
// running status and the held data byte for every byte transfer in, and
// compares each message transfer out against the oldest predicted message.
// ----------------------------------------------------------------------------
module midi_parse_checker
	import mbsp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // midi_byte[7:0]
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [OUT_BITS-1:0] m_axis_tdata,   // command, first_field, second_field, pad
	output int unsigned         fail_count,
	output int unsigned         pending,
	output int unsigned         msgs_checked
);

	parse_mode_t  mode;
	logic [7:0]   run_status;
	logic [6:0]   held;
	mbsp_result_t expected_msgs[$];
	int unsigned  fails;
	int unsigned  checked;

	function automatic mbsp_result_t parse_byte(input logic [7:0] b);
		mbsp_result_t r;
		r = '0;
		if (b[7:4] == SYS_NIBBLE) begin
			r.valid   = 1'b1;
			r.command = b;
			if (b == SYSEX_START) begin
				mode = MODE_SYSEX;
			end else if (b == SYSEX_END) begin
				mode          = MODE_IDLE;
				r.first_field = SYSEX_END_TAG;
			end
		end else if (b[7]) begin
			run_status = b;
			mode = (b[7:4] == PROG_NIBBLE) ? MODE_SINGLE : MODE_FIRST;
		end else begin
			case (mode)
				MODE_SYSEX: begin
					r.valid        = 1'b1;
					r.command      = SYSEX_START;
					r.first_field  = SYSEX_DATA_TAG;
					r.second_field = b[6:0];
				end
				MODE_FIRST: begin
					held = b[6:0];
					mode = MODE_SECOND;
				end
				MODE_SECOND: begin
					mode           = MODE_FIRST;
					r.valid        = 1'b1;
					r.command      = run_status;
					r.first_field  = held;
					r.second_field = b[6:0];
				end
				MODE_SINGLE: begin
					r.valid       = 1'b1;
					r.command     = run_status;
					r.first_field = b[6:0];
				end
				default: begin
					mode = MODE_IDLE;
				end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mbsp_result_t exp_msg;
		mbsp_result_t got;
		logic [1:0]   pad;
		if (!arst_n) begin
			mode       = MODE_IDLE;
			run_status = '0;
			held       = '0;
			expected_msgs.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.valid        = 1'b1;
				got.command      = m_axis_tdata[7:0];
				got.first_field  = m_axis_tdata[14:8];
				got.second_field = m_axis_tdata[21:15];
				pad              = m_axis_tdata[23:22];
				if (expected_msgs.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected message: cmd %h f1 %h f2 %h",
							got.command, got.first_field, got.second_field);
				end else begin
					exp_msg = expected_msgs.pop_front();
					checked++;
					if (got.command != exp_msg.command
						|| got.first_field != exp_msg.first_field
						|| got.second_field != exp_msg.second_field
						|| pad != 2'b00) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: exp cmd %h f1 %h f2 %h, got cmd %h f1 %h f2 %h pad %b",
								exp_msg.command, exp_msg.first_field, exp_msg.second_field,
								got.command, got.first_field, got.second_field, pad);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				exp_msg = parse_byte(s_axis_tdata);
				if (exp_msg.valid)
					expected_msgs.push_back(exp_msg);
			end
		end
		fail_count   <= fails;
		pending      <= expected_msgs.size();
		msgs_checked <= checked;
	end

endmodule

// ===== sim/midi_byte_stream_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_unit_tb
// Feeds the MIDI parser directed byte sequences and then random channel
// messages, sysex blocks, real-time bytes and noise, with bursty input and a
// stalling output side; the checker predicts and compares every message.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_unit_tb;
	import mbsp_pkg::*;

	localparam int unsigned NUM_BYTES      = 800;
	localparam int unsigned LONG_HOLD      = 250;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES  = 10;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata  = '0;     // midi_byte[7:0]
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_BITS-1:0] m_axis_tdata;           // command, first_field, second_field, pad

	logic        hold_request = 1'b0;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned msgs_checked;
	int unsigned bytes_sent   = 0;
	int unsigned burst_left   = 0;
	int unsigned idle_cycles  = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	midi_byte_stream_parser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	midi_parse_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.msgs_checked  (msgs_checked)
	);

	// no progress on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", idle_cycles);
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// output side: segments of always-ready, random and fixed-pattern stalls
	initial begin
		int unsigned seg;
		int unsigned style;
		int unsigned phase;
		logic        hold_done;
		hold_done = 1'b0;
		phase     = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end
			style = $urandom_range(0, 3);
			seg   = $urandom_range(10, 80);
			repeat (seg) begin
				case (style)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= $urandom_range(0, 1);
					end
					2: begin
						m_axis_tready <= (phase % 5) < 3;
					end
					default: begin
						m_axis_tready <= ($urandom_range(0, 7) != 0);
					end
				endcase
				phase++;
				@(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 20);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		bytes_sent++;
	endtask

	function automatic logic [7:0] rand_data();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'h7F;
			default: return 8'($urandom_range(0, 127));
		endcase
	endfunction

	task automatic maybe_realtime();
		if ($urandom_range(0, 9) == 0)
			send_byte(8'hF8 + 8'($urandom_range(0, 7)));
	endtask

	task automatic send_channel_msg();
		logic [7:0]  status;
		int unsigned reps;
		status = 8'h80 + 8'($urandom_range(0, 111));
		reps   = $urandom_range(1, 4);
		send_byte(status);
		repeat (reps) begin
			maybe_realtime();
			send_byte(rand_data());
			if (status[7:4] != PROG_NIBBLE) begin
				maybe_realtime();
				send_byte(rand_data());
			end
		end
	endtask

	task automatic send_sysex();
		send_byte(SYSEX_START);
		repeat ($urandom_range(0, 8)) begin
			maybe_realtime();
			send_byte(rand_data());
		end
		case ($urandom_range(0, 5))
			0:       send_byte(8'h80 + 8'($urandom_range(0, 111)));
			1:       send_byte(8'hF1 + 8'($urandom_range(0, 14)));
			default: send_byte(SYSEX_END);
		endcase
	endtask

	logic [7:0] directed_bytes[] = '{
		8'h40,                      // data with no status: ignored
		8'h90, 8'h00, 8'h7F,        // note on
		8'h7F, 8'h00,               // running status
		8'h3C, 8'hF8, 8'h40,        // real-time byte inside a message
		8'hC3, 8'h7F, 8'h00,        // program change repeats per byte
		8'hF0, 8'h55,               // sysex data
		8'hCF, 8'h2A,               // program change arriving inside sysex
		8'hF0, 8'hF7, 8'h12,        // empty sysex, then idle data
		8'hF1, 8'hFF,
		8'hE0, 8'h01, 8'hF7, 8'h22  // sysex end in mid-message drops it
	};

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);

		hold_request = 1'b1;
		while (bytes_sent < NUM_BYTES) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: send_channel_msg();
				5, 6:          send_sysex();
				7:             send_byte(8'($urandom_range(0, 255)));
				8:             send_byte(8'h80 + 8'($urandom_range(0, 111)));
				default:       send_byte(rand_data());
			endcase
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d MIDI bytes (channel, program, sysex, real-time, noise)", bytes_sent);
		$display("checked %0d messages, %0d failures, %0d left waiting",
			msgs_checked, fail_count, pending);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
